[rtl/core/pbc_pkg.sv]
package pbc_pkg;

    // Default table depth
    localparam int MAX_PARTS_DEF = 16;

    // Field widths
    localparam int OP_W       = 3;
    localparam int PART_W     = 4;
    localparam int WEIGHT_W   = 16;
    localparam int SUM_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int PCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT  = 2'd1;

    // Reset values of the configuration registers
    localparam logic [SUM_W-1:0]    LOWER_BOUND_RST = '0;
    localparam logic [PCOUNT_W-1:0] PART_COUNT_RST  = 5'd2;

    // Move status codes
    localparam logic [STATUS_W-1:0] ST_NOT_SATISFIED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GET_BETTER    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALL_SATISFIED = 2'd2;

    // Operation codes; the remaining codes do nothing
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_ADD    = 3'd1,
        OP_CHECK  = 3'd2,
        OP_COMMIT = 3'd3,
        OP_FINAL  = 3'd4
    } t_op;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_COMMIT2,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RESP
    } t_state;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load;      // capture a new request
        logic rd_item;   // read the table at source and target
        logic exec;      // apply the operation
        logic wr_src;    // second half of a commit
        logic scan_rd;   // read the table at the scan counter
        logic scan_cmp;  // compare the scanned entry with the bound
        logic res_load;  // load the result register
    } t_dp_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        t_op  op;
        logic same_part;
        logic scan_done;
    } t_dp_sts;

endpackage

[rtl/core/pbc_req_if.sv]
interface pbc_req_if;
    logic                          valid;
    logic                          ready;
    logic [pbc_pkg::OP_W-1:0]      op;
    logic [pbc_pkg::PART_W-1:0]    src_part;
    logic [pbc_pkg::PART_W-1:0]    dst_part;
    logic [pbc_pkg::WEIGHT_W-1:0]  module_weight;

    modport source (
        output valid, op, src_part, dst_part, module_weight,
        input  ready
    );

    modport sink (
        input  valid, op, src_part, dst_part, module_weight,
        output ready
    );
endinterface

[rtl/core/pbc_rsp_if.sv]
interface pbc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pbc_pkg::STATUS_W-1:0]  move_status;
    logic                          source_ok;
    logic                          all_balanced;

    modport source (
        output valid, move_status, source_ok, all_balanced,
        input  ready
    );

    modport sink (
        input  valid, move_status, source_ok, all_balanced,
        output ready
    );
endinterface

[rtl/core/pbc_ctrl.sv]
module pbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  pbc_pkg::t_dp_sts i_sts,
    output pbc_pkg::t_dp_cmd o_cmd
);

    pbc_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            pbc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pbc_pkg::S_READ;
                end
            end
            pbc_pkg::S_READ: begin
                o_cmd.rd_item = 1'b1;
                n_state = (i_sts.op == pbc_pkg::OP_FINAL) ? pbc_pkg::S_SCAN_RD
                                                          : pbc_pkg::S_EXEC;
            end
            pbc_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                // a commit between two distinct partitions needs a second write
                if (i_sts.op == pbc_pkg::OP_COMMIT && !i_sts.same_part) begin
                    n_state = pbc_pkg::S_COMMIT2;
                end else begin
                    n_state = pbc_pkg::S_RESP;
                end
            end
            pbc_pkg::S_COMMIT2: begin
                o_cmd.wr_src = 1'b1;
                n_state      = pbc_pkg::S_RESP;
            end
            pbc_pkg::S_SCAN_RD: begin
                if (i_sts.scan_done) begin
                    n_state = pbc_pkg::S_RESP;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = pbc_pkg::S_SCAN_CMP;
                end
            end
            pbc_pkg::S_SCAN_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = pbc_pkg::S_SCAN_RD;
            end
            pbc_pkg::S_RESP: begin
                // wait for the result register to drain
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = pbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pbc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/core/pbc_datapath.sv]
module pbc_datapath #(
    parameter int MAX_PARTS = pbc_pkg::MAX_PARTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [pbc_pkg::OP_W-1:0]         i_op,
    input  logic [pbc_pkg::PART_W-1:0]       i_src_part,
    input  logic [pbc_pkg::PART_W-1:0]       i_dst_part,
    input  logic [pbc_pkg::WEIGHT_W-1:0]     i_module_weight,
    input  pbc_pkg::t_dp_cmd                 i_cmd,
    output pbc_pkg::t_dp_sts                 o_sts,
    output logic [pbc_pkg::STATUS_W-1:0]     o_move_status,
    output logic                             o_source_ok,
    output logic                             o_all_balanced
);

    localparam int AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam int SW = pbc_pkg::SUM_W;

    // Configuration registers
    logic [SW-1:0]                  r_lower_bound;
    logic [pbc_pkg::PCOUNT_W-1:0]   r_part_count;

    // Captured request
    pbc_pkg::t_op                   r_op;
    logic [pbc_pkg::PART_W-1:0]     r_src;
    logic [pbc_pkg::PART_W-1:0]     r_dst;
    logic [pbc_pkg::WEIGHT_W-1:0]   r_weight;
    logic [pbc_pkg::WEIGHT_W-1:0]   r_last_weight;

    // Weight table with per-entry valid bits
    logic [SW-1:0]                  r_mem [MAX_PARTS];
    logic [MAX_PARTS-1:0]           r_valid;
    logic [SW-1:0]                  r_rd_a, r_rd_b;
    logic                           r_rd_a_v, r_rd_b_v;

    // Scan and result state
    logic [CW-1:0]                  r_cnt;
    logic                           r_ok;
    logic [pbc_pkg::STATUS_W-1:0]   r_status;
    logic                           r_src_ok;
    logic [pbc_pkg::STATUS_W-1:0]   r_move_status;
    logic                           r_source_ok;
    logic                           r_all_balanced;

    logic              src_in, dst_in;
    logic [AW-1:0]     addr_a, addr_b;
    logic              a_in;
    logic [SW-1:0]     a_val, b_val;
    logic [SW:0]       need, to_sum;
    logic              from_lt, to_lt;
    logic [CW-1:0]     scan_n;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [SW-1:0]     wdata;
    logic              do_clear;

    // Index range checks and read addresses
    assign src_in = int'(r_src) < MAX_PARTS;
    assign dst_in = int'(r_dst) < MAX_PARTS;
    assign addr_a = i_cmd.scan_rd ? r_cnt[AW-1:0] : AW'(r_src);
    assign addr_b = AW'(r_dst);
    assign a_in   = i_cmd.scan_rd ? 1'b1 : src_in;

    // Entries never written since the last clear read as zero
    assign a_val = r_rd_a_v ? r_rd_a : '0;
    assign b_val = r_rd_b_v ? r_rd_b : '0;

    // Bound comparisons at full precision
    assign need    = {1'b0, r_lower_bound} + (SW + 1)'(r_weight);
    assign from_lt = {1'b0, a_val} < need;
    assign to_sum  = {1'b0, b_val} + (SW + 1)'(r_weight);
    assign to_lt   = to_sum < {1'b0, r_lower_bound};

    // Scan length, saturated to the table depth
    assign scan_n = (int'(r_part_count) > MAX_PARTS) ? CW'(MAX_PARTS)
                                                     : CW'(r_part_count);

    // Write port selection
    always_comb begin
        we       = 1'b0;
        waddr    = AW'(r_src);
        wdata    = a_val + SW'(r_weight);
        do_clear = 1'b0;
        if (i_cmd.wr_src) begin
            we    = src_in;
            waddr = AW'(r_src);
            wdata = a_val - SW'(r_last_weight);
        end else if (i_cmd.exec) begin
            case (r_op)
                pbc_pkg::OP_CLEAR: begin
                    do_clear = 1'b1;
                end
                pbc_pkg::OP_ADD: begin
                    we    = src_in;
                    waddr = AW'(r_src);
                    wdata = a_val + SW'(r_weight);
                end
                pbc_pkg::OP_COMMIT: begin
                    // a move within one partition leaves its sum unchanged
                    we    = dst_in && (r_src != r_dst);
                    waddr = AW'(r_dst);
                    wdata = b_val + SW'(r_last_weight);
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_bound <= pbc_pkg::LOWER_BOUND_RST;
            r_part_count  <= pbc_pkg::PART_COUNT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pbc_pkg::CFG_LOWER_BOUND) begin
                r_lower_bound <= i_cfg_data[SW-1:0];
            end
            if (i_cfg_idx == pbc_pkg::CFG_PART_COUNT) begin
                r_part_count <= i_cfg_data[pbc_pkg::PCOUNT_W-1:0];
            end
        end
    end

    // Table storage and registered reads
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_item || i_cmd.scan_rd) begin
            r_rd_a   <= r_mem[addr_a];
            r_rd_b   <= r_mem[addr_b];
            r_rd_a_v <= a_in && r_valid[addr_a];
            r_rd_b_v <= dst_in && r_valid[addr_b];
        end
    end

    // Valid bits: cleared at reset and by the clear operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (do_clear) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[waddr] <= 1'b1;
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= pbc_pkg::t_op'(i_op);
            r_src    <= i_src_part;
            r_dst    <= i_dst_part;
            r_weight <= i_module_weight;
        end
    end

    // Latched move weight, scan counter and result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_weight <= '0;
            r_cnt         <= '0;
            r_ok          <= 1'b1;
            r_status      <= pbc_pkg::ST_NOT_SATISFIED;
            r_src_ok      <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt    <= '0;
                r_ok     <= 1'b1;
                r_status <= pbc_pkg::ST_NOT_SATISFIED;
                r_src_ok <= 1'b0;
            end
            if (i_cmd.exec && r_op == pbc_pkg::OP_CHECK) begin
                r_last_weight <= r_weight;
                if (from_lt) begin
                    r_status <= pbc_pkg::ST_NOT_SATISFIED;
                    r_src_ok <= 1'b0;
                end else begin
                    r_status <= to_lt ? pbc_pkg::ST_GET_BETTER : pbc_pkg::ST_ALL_SATISFIED;
                    r_src_ok <= 1'b1;
                end
            end
            if (i_cmd.scan_cmp) begin
                if (a_val < r_lower_bound) begin
                    r_ok <= 1'b0;
                end
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_move_status  <= r_status;
            r_source_ok    <= r_src_ok;
            r_all_balanced <= (r_op == pbc_pkg::OP_FINAL) && r_ok;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.same_part = (r_src == r_dst);
    assign o_sts.scan_done = (r_cnt >= scan_n);

    assign o_move_status  = r_move_status;
    assign o_source_ok    = r_source_ok;
    assign o_all_balanced = r_all_balanced;

endmodule

[rtl/core/partition_balance_checker_top.sv]
// Partition balance checker: keeps one 32-bit weight sum per partition (MAX_PARTS
// entries, wrapping modulo 2^32) and answers clear, add, check, commit and final
// requests, one result per request. Requests are handled one at a time. The weight
// table has one write port and registered reads (read, then update); a commit
// between two different partitions needs a second write state, and final reads
// min(part_count, MAX_PARTS) entries one at a time through the same port, each
// read followed by a compare state. A new request is taken while the previous
// result still waits in the output register. Clear and reset empty the table at
// once through per-entry valid bits, so there is no clearing pass. Partition
// indexes at or beyond MAX_PARTS read as zero and are never written. Write the
// configuration registers only while no request is in flight.
module partition_balance_checker_top #(
    parameter int MAX_PARTS = pbc_pkg::MAX_PARTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pbc_req_if.sink                         i_req,
    pbc_rsp_if.source                       o_rsp
);

    pbc_pkg::t_dp_cmd cmd;
    pbc_pkg::t_dp_sts sts;

    // Sequencer
    pbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Weight table, bound checks and result register
    pbc_datapath #(
        .MAX_PARTS (MAX_PARTS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_req.op),
        .i_src_part      (i_req.src_part),
        .i_dst_part      (i_req.dst_part),
        .i_module_weight (i_req.module_weight),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_move_status   (o_rsp.move_status),
        .o_source_ok     (o_rsp.source_ok),
        .o_all_balanced  (o_rsp.all_balanced)
    );

    // One request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while another is in flight");

    // source_ok is set exactly when the status is not not_satisfied
    a_status_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.source_ok == (o_rsp.move_status != pbc_pkg::ST_NOT_SATISFIED)))
        else $error("move status and source_ok disagree");

    // check and final results never mix
    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.source_ok && o_rsp.all_balanced))
        else $error("check and final fields both set");

endmodule

[tb/partition_balance_checker_top_tb.sv]
module partition_balance_checker_top_tb;
    import pbc_pkg::*;

    localparam int NPARTS          = MAX_PARTS_DEF;
    localparam int TIMEOUT_T       = 2_000_000;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 64;
    localparam int PHASE_ITEMS     = 210;
    localparam int N_PHASES        = 8;

    // Op codes the block leaves unused
    localparam logic [OP_W-1:0] OP_NOP_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_NOP_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP_HI  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] move_status;
        logic                source_ok;
        logic                all_balanced;
    } t_answer;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [PART_W-1:0]   src;
        logic [PART_W-1:0]   dst;
        logic [WEIGHT_W-1:0] weight;
    } t_move_req;

    // One line of the directed table: a register write or a request
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        t_move_req             req;
        logic                  pinned;
        t_answer               answer;
    } t_dir_row;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    pbc_req_if req_if ();
    pbc_rsp_if rsp_if ();

    // Mirror of the weight table and registers
    logic [SUM_W-1:0]    part_sum [NPARTS];
    logic [WEIGHT_W-1:0] held_weight;
    logic [SUM_W-1:0]    bound_q;
    logic [PCOUNT_W-1:0] count_q;

    t_answer answers_q[$];
    int      n_mismatch  = 0;
    bit      burst       = 1'b0;
    bit      hold_rsp    = 1'b0;
    bit      pin_en      = 1'b0;
    t_answer pin_answer  = '0;

    partition_balance_checker_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one request to the mirror and return what the block should answer
    function automatic t_answer balance_answer(t_move_req r);
        t_answer          a;
        logic [SUM_W:0]   need;
        logic [SUM_W:0]   reach;
        int               n;
        int               i;
        a = '0;
        case (r.op)
            OP_CLEAR: begin
                for (i = 0; i < NPARTS; i++) part_sum[i] = '0;
            end
            OP_ADD: begin
                part_sum[r.src] = part_sum[r.src] + SUM_W'(r.weight);
            end
            OP_CHECK: begin
                held_weight = r.weight;
                // exact sums: no wrap in the bound comparisons
                need  = {1'b0, bound_q} + (SUM_W + 1)'(r.weight);
                reach = {1'b0, part_sum[r.dst]} + (SUM_W + 1)'(r.weight);
                if ({1'b0, part_sum[r.src]} < need) begin
                    a.move_status = ST_NOT_SATISFIED;
                end else begin
                    a.source_ok   = 1'b1;
                    a.move_status = (reach < {1'b0, bound_q}) ? ST_GET_BETTER
                                                              : ST_ALL_SATISFIED;
                end
            end
            OP_COMMIT: begin
                part_sum[r.dst] = part_sum[r.dst] + SUM_W'(held_weight);
                part_sum[r.src] = part_sum[r.src] - SUM_W'(held_weight);
            end
            OP_FINAL: begin
                n = (int'(count_q) > NPARTS) ? NPARTS : int'(count_q);
                a.all_balanced = 1'b1;
                for (i = 0; i < n; i++) begin
                    if (part_sum[i] < bound_q) a.all_balanced = 1'b0;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return WEIGHT_W'($urandom_range(0, 255));
            default: return WEIGHT_W'($urandom());
        endcase
    endfunction

    function automatic t_dir_row op_row(logic [OP_W-1:0] op, logic [PART_W-1:0] s, d,
                                        logic [WEIGHT_W-1:0] w);
        t_dir_row r;
        r = '0;
        r.req = {op, s, d, w};
        return r;
    endfunction

    function automatic t_dir_row pin_row(logic [OP_W-1:0] op, logic [PART_W-1:0] s, d,
                                         logic [WEIGHT_W-1:0] w, logic [STATUS_W-1:0] st,
                                         logic ok, logic bal);
        t_dir_row r;
        r = op_row(op, s, d, w);
        r.pinned = 1'b1;
        r.answer = {st, ok, bal};
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        t_dir_row r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    // Offer one request after a random gap and hold it until taken
    task automatic send_req(input t_move_req r, input logic pin, input t_answer a);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pin_en     = pin;
        pin_answer = a;
        req_if.valid         <= 1'b1;
        req_if.op            <= r.op;
        req_if.src_part      <= r.src;
        req_if.dst_part      <= r.dst;
        req_if.module_weight <= r.weight;
        do @(posedge clk); while (!(req_if.valid && req_if.ready));
        @(negedge clk);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic [PART_W-1:0] s, d,
                         input logic [WEIGHT_W-1:0] w);
        send_req({op, s, d, w}, 1'b0, '0);
    endtask

    // Register write, only once every answer is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        req_if.valid <= 1'b0;
        while (answers_q.size() != 0) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Scoreboard: answers against the mirror, register writes, new requests
    always @(posedge clk) begin : scoreboard
        t_answer want;
        t_answer got;
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = {rsp_if.move_status, rsp_if.source_ok, rsp_if.all_balanced};
                if (answers_q.size() == 0) begin
                    n_mismatch++;
                    $display("%0t: unexpected answer status=%0d ok=%0b bal=%0b",
                             $time, got.move_status, got.source_ok, got.all_balanced);
                end else begin
                    want = answers_q.pop_front();
                    if (got.move_status !== want.move_status ||
                        got.source_ok !== want.source_ok ||
                        got.all_balanced !== want.all_balanced) begin
                        n_mismatch++;
                        $display("%0t: mismatch exp %0d %0b %0b got %0d %0b %0b",
                                 $time, want.move_status, want.source_ok, want.all_balanced,
                                 got.move_status, got.source_ok, got.all_balanced);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_LOWER_BOUND: bound_q = cfg_data;
                    CFG_PART_COUNT:  count_q = cfg_data[PCOUNT_W-1:0];
                    default: ;
                endcase
            end
            if (req_if.valid && req_if.ready) begin
                want = balance_answer({req_if.op, req_if.src_part, req_if.dst_part,
                                       req_if.module_weight});
                if (pin_en) want = pin_answer;
                answers_q.push_back(want);
            end
        end
    end

    // Answer side: random stalls, one long hold-off on request
    initial begin : rsp_drain
        int stall;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_rsp) begin
                rsp_if.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge clk);
                hold_rsp = 1'b0;
            end else begin
                stall = burst ? 0 : $urandom_range(0, 3);
                if (stall > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
            @(negedge clk);
        end
    end

    initial begin : watchdog
        #(TIMEOUT_T);
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus: reset, directed table, then random phases
    initial begin : stimulus
        t_dir_row            dir_tab[$];
        int                  ph;
        int                  sent;
        int                  pick;
        int                  part_hi;
        logic [PART_W-1:0]   s;
        logic [PART_W-1:0]   d;
        logic [WEIGHT_W-1:0] w;
        logic [SUM_W-1:0]    bnd;
        logic [PCOUNT_W-1:0] cnt;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.op            = OP_CLEAR;
        req_if.src_part      = '0;
        req_if.dst_part      = '0;
        req_if.module_weight = '0;
        for (ph = 0; ph < NPARTS; ph++) part_sum[ph] = '0;
        held_weight = '0;
        bound_q     = LOWER_BOUND_RST;
        count_q     = PART_COUNT_RST;

        // empty table after reset meets a zero bound
        dir_tab.push_back(pin_row(OP_FINAL, 4'd0, 4'd0, 16'h0000, ST_NOT_SATISFIED, 1'b0, 1'b1));
        dir_tab.push_back(pin_row(OP_CHECK, 4'd0, 4'd15, 16'h0000, ST_ALL_SATISFIED, 1'b1, 1'b0));
        dir_tab.push_back(op_row(OP_ADD, 4'd0, 4'd0, 16'hFFFF));
        dir_tab.push_back(op_row(OP_ADD, 4'd15, 4'd0, 16'hFFFF));
        // largest bound: the exact sum never lets a move through
        dir_tab.push_back(cfg_row(CFG_LOWER_BOUND, 32'hFFFF_FFFF));
        dir_tab.push_back(pin_row(OP_CHECK, 4'd0, 4'd15, 16'hFFFF, ST_NOT_SATISFIED, 1'b0, 1'b0));
        dir_tab.push_back(pin_row(OP_CHECK, 4'd15, 4'd0, 16'h0000, ST_NOT_SATISFIED, 1'b0, 1'b0));
        dir_tab.push_back(pin_row(OP_FINAL, 4'd0, 4'd0, 16'h0000, ST_NOT_SATISFIED, 1'b0, 1'b0));
        dir_tab.push_back(cfg_row(CFG_LOWER_BOUND, 32'd100));
        // zero partitions in use: final always balanced
        dir_tab.push_back(cfg_row(CFG_PART_COUNT, 32'd0));
        dir_tab.push_back(pin_row(OP_FINAL, 4'd3, 4'd9, 16'h1234, ST_NOT_SATISFIED, 1'b0, 1'b1));
        dir_tab.push_back(pin_row(OP_CHECK, 4'd0, 4'd1, 16'd50, ST_GET_BETTER, 1'b1, 1'b0));
        dir_tab.push_back(op_row(OP_CHECK, 4'd0, 4'd1, 16'd1000));
        dir_tab.push_back(op_row(OP_COMMIT, 4'd0, 4'd1, 16'h0000));
        // commit onto itself leaves the sum alone
        dir_tab.push_back(op_row(OP_COMMIT, 4'd3, 4'd3, 16'hFFFF));
        dir_tab.push_back(pin_row(OP_NOP_LO, 4'd15, 4'd15, 16'hFFFF, ST_NOT_SATISFIED, 1'b0, 1'b0));
        dir_tab.push_back(pin_row(OP_NOP_MID, 4'd0, 4'd0, 16'h0000, ST_NOT_SATISFIED, 1'b0, 1'b0));
        dir_tab.push_back(pin_row(OP_NOP_HI, 4'd10, 4'd5, 16'hAAAA, ST_NOT_SATISFIED, 1'b0, 1'b0));
        // count above the table size saturates
        dir_tab.push_back(cfg_row(CFG_PART_COUNT, 32'd31));
        dir_tab.push_back(pin_row(OP_FINAL, 4'd0, 4'd0, 16'h0000, ST_NOT_SATISFIED, 1'b0, 1'b0));
        // drive an empty partition below zero, then wrap it back
        dir_tab.push_back(op_row(OP_CHECK, 4'd5, 4'd6, 16'hFFFF));
        dir_tab.push_back(op_row(OP_COMMIT, 4'd5, 4'd6, 16'h5555));
        dir_tab.push_back(op_row(OP_ADD, 4'd5, 4'd0, 16'hFFFF));
        dir_tab.push_back(op_row(OP_CHECK, 4'd6, 4'd5, 16'hFFFF));
        dir_tab.push_back(op_row(OP_CLEAR, 4'd7, 4'd8, 16'h00FF));
        dir_tab.push_back(cfg_row(CFG_PART_COUNT, 32'd16));
        dir_tab.push_back(pin_row(OP_FINAL, 4'd0, 4'd0, 16'h0000, ST_NOT_SATISFIED, 1'b0, 1'b0));
        dir_tab.push_back(cfg_row(CFG_LOWER_BOUND, 32'd0));
        dir_tab.push_back(pin_row(OP_FINAL, 4'd0, 4'd0, 16'h0000, ST_NOT_SATISFIED, 1'b0, 1'b1));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                write_reg(dir_tab[k].cfg_idx, dir_tab[k].cfg_val);
            end else begin
                send_req(dir_tab[k].req, dir_tab[k].pinned, dir_tab[k].answer);
            end
        end

        // Random phases: mostly add and check/commit pairs
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin bnd = $urandom_range(0, 300000); cnt = 5'd16; part_hi = 15; end
                1: begin bnd = '0;                        cnt = 5'd1;  part_hi = 3;  end
                2: begin bnd = '1;                        cnt = 5'd0;  part_hi = 15; end
                3: begin bnd = $urandom_range(0, 600000); cnt = 5'd31; part_hi = 1;  end
                4: begin bnd = $urandom();                cnt = 5'd17; part_hi = 15; end
                5: begin bnd = $urandom_range(0, 100000);
                         cnt = PCOUNT_W'($urandom_range(0, 31));
                         part_hi = 7; end
                6: begin bnd = $urandom_range(0, 200000); cnt = 5'd2;  part_hi = 15; end
                default: begin bnd = $urandom_range(0, 400000); cnt = 5'd16; part_hi = 3; end
            endcase
            write_reg(CFG_LOWER_BOUND, bnd);
            write_reg(CFG_PART_COUNT, CFG_DATA_W'(cnt));
            burst = (ph == 1) || (ph == 4);
            if (ph == 2) hold_rsp = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 199);
                s = PART_W'($urandom_range(0, part_hi));
                d = ($urandom_range(0, 9) == 0) ? s : PART_W'($urandom_range(0, part_hi));
                w = pick_weight();
                if (pick < 68) begin
                    issue(OP_ADD, s, d, w);
                    sent++;
                end else if (pick < 156) begin
                    issue(OP_CHECK, s, d, w);
                    if ($urandom_range(0, 7) != 0) begin
                        issue(OP_COMMIT, s, d, WEIGHT_W'($urandom()));
                    end else begin
                        issue(OP_COMMIT, PART_W'($urandom_range(0, part_hi)),
                              PART_W'($urandom_range(0, part_hi)), WEIGHT_W'($urandom()));
                    end
                    sent += 2;
                end else if (pick < 176) begin
                    issue(OP_FINAL, s, d, w);
                    sent++;
                end else if (pick < 186) begin
                    issue(OP_CHECK, s, d, w);
                    sent++;
                end else if (pick < 192) begin
                    issue(OP_COMMIT, s, d, w);
                    sent++;
                end else if (pick < 198) begin
                    issue(OP_W'($urandom_range(OP_NOP_LO, OP_NOP_HI)), s, d, w);
                    sent++;
                end else begin
                    issue(OP_CLEAR, s, d, w);
                    sent++;
                end
            end
            burst = 1'b0;
        end

        req_if.valid <= 1'b0;
        while (answers_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (n_mismatch == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/pbc_pkg.sv
rtl/core/pbc_req_if.sv
rtl/core/pbc_rsp_if.sv
rtl/core/pbc_ctrl.sv
rtl/core/pbc_datapath.sv
rtl/core/partition_balance_checker_top.sv
tb/partition_balance_checker_top_tb.sv
